>>> rtl/cpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_pkg
// shared types and constants of the closest point on triangle block
// ----------------------------------------------------------------------------
package cpt_pkg;

  localparam int COORD_W = 32;

  typedef enum logic [2:0] {
    REG_VERT_A  = 3'd0,
    REG_VERT_B  = 3'd1,
    REG_EDGE_AB = 3'd2,
    REG_VERT_C  = 3'd3,
    REG_EDGE_AC = 3'd4,
    REG_EDGE_BC = 3'd5,
    REG_FACE    = 3'd6
  } cpt_region_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic signed [COORD_W-1:0] vert_a_x;
    logic signed [COORD_W-1:0] vert_a_y;
    logic signed [COORD_W-1:0] vert_a_z;
    logic signed [COORD_W-1:0] vert_b_x;
    logic signed [COORD_W-1:0] vert_b_y;
    logic signed [COORD_W-1:0] vert_b_z;
    logic signed [COORD_W-1:0] vert_c_x;
    logic signed [COORD_W-1:0] vert_c_y;
    logic signed [COORD_W-1:0] vert_c_z;
  } cpt_query_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] closest_x;
    logic signed [COORD_W-1:0] closest_y;
    logic signed [COORD_W-1:0] closest_z;
    logic        [2:0]         region;
  } cpt_result_t;

endpackage
`default_nettype wire

>>> rtl/cpt_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_mul
// pipelined signed shift-add multiplier, one multiplier bit per stage
// ----------------------------------------------------------------------------
module cpt_mul #(
  parameter int WA = 33,
  parameter int WB = 33
) (
  input  logic               clk,
  input  logic [WA-1:0]      a,
  input  logic [WB-1:0]      b,
  output logic [WA+WB-1:0]   p
);

  localparam int PW = WA + WB;

  logic [PW-1:0] acc [WB];
  logic [PW-1:0] sh  [WB];
  logic [WB-1:0] bb  [WB];

  always_ff @(posedge clk) begin
    acc[0] <= b[0] ? {{WB{a[WA-1]}}, a} : '0;
    sh[0]  <= {{(WB-1){a[WA-1]}}, a, 1'b0};
    bb[0]  <= b;
  end

  for (genvar k = 1; k < WB; k++) begin : g_stage
    logic [PW-1:0] term;
    assign term = bb[k-1][k] ? sh[k-1] : '0;
    always_ff @(posedge clk) begin
      // top bit of b carries negative weight
      if (k == WB - 1) begin
        acc[k] <= acc[k-1] - term;
      end else begin
        acc[k] <= acc[k-1] + term;
      end
      sh[k] <= {sh[k-1][PW-2:0], 1'b0};
      bb[k] <= bb[k-1];
    end
  end

  assign p = acc[WB-1];

endmodule
`default_nettype wire

>>> rtl/closest_point_on_triangle_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// closest_point_on_triangle_top
// closest point of a triangle to a query point by voronoi region
// ----------------------------------------------------------------------------
// throughput: one beat per cycle, busy stays low
// latency is set by the bit-serial multiplier stages and the restoring divider
// reset clears only the valid line; no clearing pass
module closest_point_on_triangle_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  cpt_pkg::cpt_query_t query,
  output logic                done,
  output cpt_pkg::cpt_result_t result
);
  import cpt_pkg::*;

  localparam int W   = COORD_W;
  localparam int E   = W + 1;
  localparam int D   = 2 * E + 2;
  localparam int V   = 2 * D + 1;
  localparam int DW  = V + 2;
  localparam int N   = E + V + 1;
  localparam int XW  = N + 2;
  localparam int YW  = DW + 1;
  localparam int LAT = 2 * E + D + XW + 7;

  typedef struct packed {
    logic [2:0][W-1:0] a;
    logic [2:0][W-1:0] b;
    logic [2:0][W-1:0] c;
    logic [2:0][E-1:0] ab;
    logic [2:0][E-1:0] ac;
    logic [2:0][E-1:0] cb;
  } s1_t;

  typedef struct packed {
    s1_t               s;
    logic [5:0][D-1:0] d;
  } s2_t;

  typedef struct packed {
    logic [2:0]        region;
    logic [2:0][W-1:0] base;
    logic [DW-1:0]     den;
  } s3_t;

  typedef struct packed {
    logic [2:0]        region;
    logic [2:0][W-1:0] base;
    logic [2:0]        neg;
    logic              zden;
    logic [YW-1:0]     y;
  } s6_t;

  logic [LAT-1:0] vld;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
  end

  // stage 1: edge and offset vectors
  logic [2:0][W-1:0] qp, qa, qb, qc;
  assign qp = {query.point_z, query.point_y, query.point_x};
  assign qa = {query.vert_a_z, query.vert_a_y, query.vert_a_x};
  assign qb = {query.vert_b_z, query.vert_b_y, query.vert_b_x};
  assign qc = {query.vert_c_z, query.vert_c_y, query.vert_c_x};

  s1_t               r1_s;
  logic [2:0][E-1:0] ap, bp, cp;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      r1_s.a[i]  <= qa[i];
      r1_s.b[i]  <= qb[i];
      r1_s.c[i]  <= qc[i];
      r1_s.ab[i] <= {qb[i][W-1], qb[i]} - {qa[i][W-1], qa[i]};
      r1_s.ac[i] <= {qc[i][W-1], qc[i]} - {qa[i][W-1], qa[i]};
      r1_s.cb[i] <= {qc[i][W-1], qc[i]} - {qb[i][W-1], qb[i]};
      ap[i]      <= {qp[i][W-1], qp[i]} - {qa[i][W-1], qa[i]};
      bp[i]      <= {qp[i][W-1], qp[i]} - {qb[i][W-1], qb[i]};
      cp[i]      <= {qp[i][W-1], qp[i]} - {qc[i][W-1], qc[i]};
    end
  end

  // dot product terms d1..d6
  logic [5:0][2:0][2*E-1:0] pr1;

  for (genvar k = 0; k < 6; k++) begin : g_dot
    for (genvar i = 0; i < 3; i++) begin : g_axis
      cpt_mul #(.WA(E), .WB(E)) u_mul (
        .clk (clk),
        .a   ((k % 2 == 0) ? r1_s.ab[i] : r1_s.ac[i]),
        .b   ((k / 2 == 0) ? ap[i] : ((k / 2 == 1) ? bp[i] : cp[i])),
        .p   (pr1[k][i])
      );
    end
  end

  s1_t s1_dl [E];

  always_ff @(posedge clk) begin
    s1_dl[0] <= r1_s;
    for (int k = 1; k < E; k++) begin
      s1_dl[k] <= s1_dl[k-1];
    end
  end

  s2_t r2_s;

  always_ff @(posedge clk) begin
    r2_s.s <= s1_dl[E-1];
    for (int k = 0; k < 6; k++) begin
      r2_s.d[k] <= {{2{pr1[k][0][2*E-1]}}, pr1[k][0]}
                 + {{2{pr1[k][1][2*E-1]}}, pr1[k][1]}
                 + {{2{pr1[k][2][2*E-1]}}, pr1[k][2]};
    end
  end

  // barycentric cross terms
  localparam int LI [6] = '{0, 2, 4, 0, 2, 4};
  localparam int RI [6] = '{3, 1, 1, 5, 5, 3};

  logic [5:0][2*D-1:0] pr2;

  for (genvar j = 0; j < 6; j++) begin : g_bary
    cpt_mul #(.WA(D), .WB(D)) u_mul (
      .clk (clk),
      .a   (r2_s.d[LI[j]]),
      .b   (r2_s.d[RI[j]]),
      .p   (pr2[j])
    );
  end

  s2_t s2_dl [D];

  always_ff @(posedge clk) begin
    s2_dl[0] <= r2_s;
    for (int k = 1; k < D; k++) begin
      s2_dl[k] <= s2_dl[k-1];
    end
  end

  s2_t          r3_s;
  logic [V-1:0] r3_va, r3_vb, r3_vc;

  always_ff @(posedge clk) begin
    r3_s  <= s2_dl[D-1];
    r3_vc <= {pr2[0][2*D-1], pr2[0]} - {pr2[1][2*D-1], pr2[1]};
    r3_vb <= {pr2[2][2*D-1], pr2[2]} - {pr2[3][2*D-1], pr2[3]};
    r3_va <= {pr2[4][2*D-1], pr2[4]} - {pr2[5][2*D-1], pr2[5]};
  end

  // region decision
  logic [D:0]   d43, d56, d1m3, d2m6;
  logic [D+1:0] dbc;
  logic [5:0]   dneg, dpos;
  logic         n43, p43, n56, p56, vapos, vbpos, vcpos;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      dneg[k] = r3_s.d[k][D-1];
      dpos[k] = !r3_s.d[k][D-1] && (|r3_s.d[k]);
    end
    d43   = {r3_s.d[3][D-1], r3_s.d[3]} - {r3_s.d[2][D-1], r3_s.d[2]};
    d56   = {r3_s.d[4][D-1], r3_s.d[4]} - {r3_s.d[5][D-1], r3_s.d[5]};
    d1m3  = {r3_s.d[0][D-1], r3_s.d[0]} - {r3_s.d[2][D-1], r3_s.d[2]};
    d2m6  = {r3_s.d[1][D-1], r3_s.d[1]} - {r3_s.d[5][D-1], r3_s.d[5]};
    dbc   = {d43[D], d43} + {d56[D], d56};
    n43   = d43[D];
    p43   = !d43[D] && (|d43);
    n56   = d56[D];
    p56   = !d56[D] && (|d56);
    vapos = !r3_va[V-1] && (|r3_va);
    vbpos = !r3_vb[V-1] && (|r3_vb);
    vcpos = !r3_vc[V-1] && (|r3_vc);
  end

  cpt_region_e       dec_region;
  logic [2:0][W-1:0] dec_base;
  logic [2:0][E-1:0] dec_e1, dec_e2;
  logic [V-1:0]      dec_m1, dec_m2;
  logic [DW-1:0]     dec_den;

  always_comb begin
    dec_region = REG_FACE;
    dec_base   = r3_s.s.a;
    dec_e1     = r3_s.s.ab;
    dec_e2     = r3_s.s.ac;
    dec_m1     = r3_vb;
    dec_m2     = r3_vc;
    dec_den    = {{2{r3_va[V-1]}}, r3_va} + {{2{r3_vb[V-1]}}, r3_vb}
               + {{2{r3_vc[V-1]}}, r3_vc};
    if (!dpos[0] && !dpos[1]) begin
      dec_region = REG_VERT_A;
      dec_e1     = '0;
      dec_e2     = '0;
      dec_m1     = '0;
      dec_m2     = '0;
      dec_den    = '0;
    end else if (!dneg[2] && !p43) begin
      dec_region = REG_VERT_B;
      dec_base   = r3_s.s.b;
      dec_e1     = '0;
      dec_e2     = '0;
      dec_m1     = '0;
      dec_m2     = '0;
      dec_den    = '0;
    end else if (!vcpos && !dneg[0] && !dpos[2]) begin
      dec_region = REG_EDGE_AB;
      dec_m1     = {{(V-D){r3_s.d[0][D-1]}}, r3_s.d[0]};
      dec_e2     = '0;
      dec_m2     = '0;
      dec_den    = {{(DW-D-1){d1m3[D]}}, d1m3};
    end else if (!dneg[5] && !p56) begin
      dec_region = REG_VERT_C;
      dec_base   = r3_s.s.c;
      dec_e1     = '0;
      dec_e2     = '0;
      dec_m1     = '0;
      dec_m2     = '0;
      dec_den    = '0;
    end else if (!vbpos && !dneg[1] && !dpos[5]) begin
      dec_region = REG_EDGE_AC;
      dec_e1     = r3_s.s.ac;
      dec_m1     = {{(V-D){r3_s.d[1][D-1]}}, r3_s.d[1]};
      dec_e2     = '0;
      dec_m2     = '0;
      dec_den    = {{(DW-D-1){d2m6[D]}}, d2m6};
    end else if (!vapos && !n43 && !n56) begin
      dec_region = REG_EDGE_BC;
      dec_base   = r3_s.s.b;
      dec_e1     = r3_s.s.cb;
      dec_m1     = {{(V-D-1){d43[D]}}, d43};
      dec_e2     = '0;
      dec_m2     = '0;
      dec_den    = {{(DW-D-2){dbc[D+1]}}, dbc};
    end
  end

  s3_t               r4_s;
  logic [2:0][E-1:0] r4_e1, r4_e2;
  logic [V-1:0]      r4_m1, r4_m2;

  always_ff @(posedge clk) begin
    r4_s.region <= dec_region;
    r4_s.base   <= dec_base;
    r4_s.den    <= dec_den;
    r4_e1       <= dec_e1;
    r4_e2       <= dec_e2;
    r4_m1       <= dec_m1;
    r4_m2       <= dec_m2;
  end

  // offset numerators
  logic [2:0][V+E-1:0] pm1, pm2;

  for (genvar i = 0; i < 3; i++) begin : g_num
    cpt_mul #(.WA(V), .WB(E)) u_mul1 (
      .clk (clk),
      .a   (r4_m1),
      .b   (r4_e1[i]),
      .p   (pm1[i])
    );
    cpt_mul #(.WA(V), .WB(E)) u_mul2 (
      .clk (clk),
      .a   (r4_m2),
      .b   (r4_e2[i]),
      .p   (pm2[i])
    );
  end

  s3_t s3_dl [E];

  always_ff @(posedge clk) begin
    s3_dl[0] <= r4_s;
    for (int k = 1; k < E; k++) begin
      s3_dl[k] <= s3_dl[k-1];
    end
  end

  s3_t               r5_s;
  logic [2:0][N-1:0] r5_num;

  always_ff @(posedge clk) begin
    r5_s <= s3_dl[E-1];
    for (int i = 0; i < 3; i++) begin
      r5_num[i] <= {pm1[i][V+E-1], pm1[i]} + {pm2[i][V+E-1], pm2[i]};
    end
  end

  // rounding set-up: q = (2|n| + |d|) / (2|d|)
  logic [DW-1:0]     dabs;
  logic [2:0][N-1:0] nabs;

  always_comb begin
    dabs = r5_s.den[DW-1] ? (~r5_s.den + 1'b1) : r5_s.den;
    for (int i = 0; i < 3; i++) begin
      nabs[i] = r5_num[i][N-1] ? (~r5_num[i] + 1'b1) : r5_num[i];
    end
  end

  s6_t                r6_s;
  logic [2:0][XW-1:0] r6_x;

  always_ff @(posedge clk) begin
    r6_s.region <= r5_s.region;
    r6_s.base   <= r5_s.base;
    r6_s.zden   <= (r5_s.den == '0);
    r6_s.y      <= {dabs, 1'b0};
    for (int i = 0; i < 3; i++) begin
      r6_s.neg[i] <= r5_num[i][N-1] ^ r5_s.den[DW-1];
      r6_x[i]     <= {1'b0, nabs[i], 1'b0} + {{(XW-DW){1'b0}}, dabs};
    end
  end

  // restoring divider, one quotient bit per stage
  function automatic logic [YW+XW-1:0] div_step(input logic [YW-1:0] r,
                                                input logic [XW-1:0] x,
                                                input logic [YW-1:0] y);
    logic [YW:0] sh;
    logic [YW:0] df;
    sh = {r, x[XW-1]};
    df = sh - {1'b0, y};
    if (!df[YW]) begin
      return {df[YW-1:0], x[XW-2:0], 1'b1};
    end
    return {sh[YW-1:0], x[XW-2:0], 1'b0};
  endfunction

  logic [2:0][YW-1:0] rem [XW];
  logic [2:0][XW-1:0] xq  [XW];
  s6_t                s6_dl [XW];

  always_ff @(posedge clk) begin
    s6_dl[0] <= r6_s;
    for (int i = 0; i < 3; i++) begin
      {rem[0][i], xq[0][i]} <= div_step('0, r6_x[i], r6_s.y);
    end
  end

  for (genvar k = 1; k < XW; k++) begin : g_div
    always_ff @(posedge clk) begin
      s6_dl[k] <= s6_dl[k-1];
      for (int i = 0; i < 3; i++) begin
        {rem[k][i], xq[k][i]} <= div_step(rem[k-1][i], xq[k-1][i], s6_dl[k-1].y);
      end
    end
  end

  // final place and saturation
  localparam logic [XW+1:0] HI = {{(XW+3-W){1'b0}}, {(W-1){1'b1}}};
  localparam logic [XW+1:0] LO = ~HI;

  s6_t                s_out;
  logic [2:0][XW:0]   sq;
  logic [2:0][XW+1:0] rs;
  logic [2:0][W-1:0]  coord;

  assign s_out = s6_dl[XW-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq[i] = s_out.neg[i] ? (~{1'b0, xq[XW-1][i]} + 1'b1) : {1'b0, xq[XW-1][i]};
      rs[i] = {{(XW+2-W){s_out.base[i][W-1]}}, s_out.base[i]} + {sq[i][XW], sq[i]};
      if (s_out.zden) begin
        coord[i] = s_out.base[i];
      end else if ($signed(rs[i]) > $signed(HI)) begin
        coord[i] = HI[W-1:0];
      end else if ($signed(rs[i]) < $signed(LO)) begin
        coord[i] = LO[W-1:0];
      end else begin
        coord[i] = rs[i][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    result.closest_x <= coord[0];
    result.closest_y <= coord[1];
    result.closest_z <= coord[2];
    result.region    <= s_out.region;
  end

  assign done = vld[LAT-1];

`ifndef SYNTHESIS
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result beat without a matching start");

  a_region_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.region != 3'd7))
    else $error("unused region code");

  a_vert_a: assert property (@(posedge clk) disable iff (rst)
    (done && (result.region == REG_VERT_A)) |->
      (result.closest_x == $past(query.vert_a_x, LAT)))
    else $error("vertex a result differs from vertex a");

  a_vert_b: assert property (@(posedge clk) disable iff (rst)
    (done && (result.region == REG_VERT_B)) |->
      (result.closest_y == $past(query.vert_b_y, LAT)))
    else $error("vertex b result differs from vertex b");
`endif

endmodule
`default_nettype wire

>>> tb/sv/cpt_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_result_checker
// watches the query and result channels of the closest point block, works
// out the closest point and voronoi region of every accepted query with
// exact wide arithmetic, and compares each result beat in order
// ----------------------------------------------------------------------------
module cpt_result_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  cpt_pkg::cpt_query_t  query,
  input  logic                 done,
  input  cpt_pkg::cpt_result_t result,
  output int                   errors,
  output int                   pending,
  output int                   results_seen,
  output int                   region_hits [7]
);
  import cpt_pkg::*;

  typedef logic signed [255:0] wide_t;

  cpt_result_t closest_q[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    errors++;
  endtask

  // base + round(num / den) with ties away from zero, saturated
  function automatic logic signed [31:0] offset_coord(input wide_t base, input wide_t num,
                                                     input wide_t den);
    wide_t n, d, q, r;
    if (den == 0) return base[31:0];
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (2 * n + d) / (2 * d);
    r = ((num < 0) != (den < 0)) ? base - q : base + q;
    if (r > wide_t'(32'sh7fffffff)) return 32'sh7fffffff;
    if (r < -wide_t'(33'sh080000000)) return 32'sh80000000;
    return r[31:0];
  endfunction

  function automatic wide_t dot(input wide_t u [3], input wide_t v [3]);
    return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
  endfunction

  function automatic cpt_result_t closest_point(input cpt_query_t q);
    wide_t p [3], a [3], b [3], c [3], ab [3], ac [3], ap [3], bp [3], cp [3];
    wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, num, den;
    logic signed [31:0] res [3];
    cpt_region_e reg_code;
    cpt_result_t r;
    p = '{wide_t'(q.point_x), wide_t'(q.point_y), wide_t'(q.point_z)};
    a = '{wide_t'(q.vert_a_x), wide_t'(q.vert_a_y), wide_t'(q.vert_a_z)};
    b = '{wide_t'(q.vert_b_x), wide_t'(q.vert_b_y), wide_t'(q.vert_b_z)};
    c = '{wide_t'(q.vert_c_x), wide_t'(q.vert_c_y), wide_t'(q.vert_c_z)};
    for (int i = 0; i < 3; i++) begin
      ab[i] = b[i] - a[i];
      ac[i] = c[i] - a[i];
      ap[i] = p[i] - a[i];
      bp[i] = p[i] - b[i];
      cp[i] = p[i] - c[i];
    end
    d1 = dot(ab, ap); d2 = dot(ac, ap);
    d3 = dot(ab, bp); d4 = dot(ac, bp);
    d5 = dot(ab, cp); d6 = dot(ac, cp);
    vc = d1 * d4 - d3 * d2;
    vb = d5 * d2 - d1 * d6;
    va = d3 * d6 - d5 * d4;
    if (d1 <= 0 && d2 <= 0) begin
      reg_code = REG_VERT_A;
      for (int i = 0; i < 3; i++) res[i] = a[i][31:0];
    end else if (d3 >= 0 && d4 - d3 <= 0) begin
      reg_code = REG_VERT_B;
      for (int i = 0; i < 3; i++) res[i] = b[i][31:0];
    end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
      reg_code = REG_EDGE_AB;
      for (int i = 0; i < 3; i++) res[i] = offset_coord(a[i], ab[i] * d1, d1 - d3);
    end else if (d6 >= 0 && d5 - d6 <= 0) begin
      reg_code = REG_VERT_C;
      for (int i = 0; i < 3; i++) res[i] = c[i][31:0];
    end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
      reg_code = REG_EDGE_AC;
      for (int i = 0; i < 3; i++) res[i] = offset_coord(a[i], ac[i] * d2, d2 - d6);
    end else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0) begin
      reg_code = REG_EDGE_BC;
      num = d4 - d3;
      den = num + (d5 - d6);
      for (int i = 0; i < 3; i++) res[i] = offset_coord(b[i], (c[i] - b[i]) * num, den);
    end else begin
      reg_code = REG_FACE;
      den = va + vb + vc;
      for (int i = 0; i < 3; i++)
        res[i] = offset_coord(a[i], ab[i] * vb + ac[i] * vc, den);
    end
    r.closest_x = res[0];
    r.closest_y = res[1];
    r.closest_z = res[2];
    r.region    = reg_code;
    return r;
  endfunction

  assign pending = closest_q.size();

  always @(posedge clk) begin
    cpt_result_t want;
    if (rst) begin
      errors       <= 0;
      results_seen <= 0;
      for (int i = 0; i < 7; i++) region_hits[i] <= 0;
      closest_q.delete();
    end else begin
      if (start && !busy) closest_q.push_back(closest_point(query));
      if (done) begin
        results_seen <= results_seen + 1;
        if (closest_q.size() == 0) begin
          $display("%0t: result beat with nothing outstanding", $time);
          errors++;
        end else begin
          want = closest_q.pop_front();
          if (want.region < 7) region_hits[want.region] <= region_hits[want.region] + 1;
          if (result.closest_x !== want.closest_x)
            report("closest_x", result.closest_x, want.closest_x);
          if (result.closest_y !== want.closest_y)
            report("closest_y", result.closest_y, want.closest_y);
          if (result.closest_z !== want.closest_z)
            report("closest_z", result.closest_z, want.closest_z);
          if (result.region !== want.region)
            report("region", 32'(result.region), 32'(want.region));
        end
      end
    end
  end

endmodule

>>> tb/sv/tb_closest_point_on_triangle_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_closest_point_on_triangle_top
// drives directed and random point/triangle queries with bursts of idle
// cycles into the block and leaves prediction and comparison to the checker
// ----------------------------------------------------------------------------
module tb_closest_point_on_triangle_top;
  import cpt_pkg::*;

  localparam int LATENCY   = 314;
  localparam int STALL_MAX = 4000;
  localparam int N_RANDOM  = 1000;
  localparam int CALM_TAIL = 150;

  logic        clk, rst, start, busy, done;
  cpt_query_t  query;
  cpt_result_t result;
  int          errors, pending, results_seen, idle_cycles;
  int          region_hits [7];
  int          queries_sent;

  closest_point_on_triangle_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .query(query), .done(done), .result(result)
  );

  cpt_result_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .query(query),
    .done(done), .result(result), .errors(errors), .pending(pending),
    .results_seen(results_seen), .region_hits(region_hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // no beat in either direction for too long ends the run
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_MAX) begin
      $display("watchdog: no beat for %0d cycles", STALL_MAX);
      $display("tb_closest_point_on_triangle_top: done, errors");
      $finish;
    end
  end

  function automatic cpt_query_t make_query(input logic signed [31:0] v [12]);
    return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]};
  endfunction

  task automatic send(input cpt_query_t q, input bit allow_gap);
    int gap;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    query <= q;
    do @(posedge clk); while (busy);
    queries_sent++;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] coord(input int mode);
    case (mode)
      0: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
      1: return $urandom;
      2: return $signed($urandom_range(0, 16)) - 8;
      default: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
    endcase
  endfunction

  task automatic random_query(input bit allow_gap);
    logic signed [31:0] v [12];
    int mode, shape;
    mode  = $urandom_range(0, 9);
    mode  = (mode < 5) ? 0 : (mode < 7) ? 3 : (mode < 9) ? 1 : 2;
    shape = $urandom_range(0, 9);
    for (int i = 0; i < 12; i++) v[i] = coord(mode);
    case (shape)
      0: for (int i = 0; i < 3; i++) begin  // coincident vertices
        v[6 + i] = v[3 + i];
        v[9 + i] = v[3 + i];
      end
      1: for (int i = 0; i < 3; i++) v[9 + i] = v[6 + i];
      2: for (int i = 0; i < 3; i++)  // collinear
        v[9 + i] = v[3 + i] + 2 * (v[6 + i] - v[3 + i]);
      3: for (int i = 0; i < 3; i++)
        v[i] = (v[3 + i] >>> 2) + (v[6 + i] >>> 2) + (v[9 + i] >>> 1);
      default: ;
    endcase
    send(make_query(v), allow_gap);
  endtask

  localparam logic signed [31:0] ONE = 32'sh00010000;
  localparam logic signed [31:0] MX  = 32'sh7fffffff;
  localparam logic signed [31:0] MN  = 32'sh80000000;

  initial begin
    logic signed [31:0] v [12];
    rst          = 1'b1;
    start        = 1'b0;
    query        = '0;
    queries_sent = 0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // unit triangle a=0, b=(1,0,0), c=(0,1,0); point moved through each region
    v = '{-ONE, -ONE, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0};        send(make_query(v), 1'b0);
    v = '{2 * ONE, -ONE, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0};       send(make_query(v), 1'b0);
    v = '{ONE / 2, -ONE, 3, 0, 0, 0, ONE, 0, 0, 0, ONE, 0};       send(make_query(v), 1'b0);
    v = '{-ONE, 2 * ONE, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0};       send(make_query(v), 1'b0);
    v = '{-ONE, ONE / 3, -ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0};    send(make_query(v), 1'b0);
    v = '{ONE, ONE, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0};          send(make_query(v), 1'b0);
    v = '{ONE / 4, ONE / 4, 5 * ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0}; send(make_query(v), 1'b0);
    // small integer triangles: one query on edge ab, one at vertex b
    v = '{1, -ONE, 0, 0, 0, 0, 2, 0, 0, 0, ONE, 0};               send(make_query(v), 1'b0);
    v = '{-1, 5, 0, 0, 0, 0, 0, 3, 0, 2, 0, 0};                   send(make_query(v), 1'b0);
    // degenerate triangles
    v = '{ONE, 2 * ONE, 3 * ONE, 7, 7, 7, 7, 7, 7, 7, 7, 7};      send(make_query(v), 1'b0);
    v = '{ONE, ONE, 0, 0, 0, 0, ONE, 0, 0, 2 * ONE, 0, 0};        send(make_query(v), 1'b0);
    v = '{ONE / 2, ONE, 0, 0, 0, 0, ONE, ONE, 0, ONE, ONE, 0};    send(make_query(v), 1'b0);
    // extremes of the coordinate range
    v = '{MX, MX, MX, MN, MN, MN, MX, MN, MN, MN, MX, MN};        send(make_query(v), 1'b0);
    v = '{MN, MN, MN, MX, MX, MX, MN, MX, MX, MX, MN, MX};        send(make_query(v), 1'b0);
    v = '{0, 0, MX, MN, MN, 0, MX, MN, 0, 0, MX, 0};              send(make_query(v), 1'b0);
    v = '{MX, MN, 0, MN, MN, MN, MX, MX, MX, MN, MX, 0};          send(make_query(v), 1'b0);
    v = '{-1, -1, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0};                 send(make_query(v), 1'b0);
    v = '{MN, 0, 0, MX, MN, 0, MX, MX, 0, MN, MX, 0};             send(make_query(v), 1'b0);

    for (int n = 0; n < N_RANDOM; n++) random_query(n < N_RANDOM - CALM_TAIL);
    start <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 20) @(negedge clk);

    $display("%0d queries, %0d results, %0d mismatches, %0d still outstanding",
             queries_sent, results_seen, errors, pending);
    $display("regions va/vb/eab/vc/eac/ebc/face: %0d %0d %0d %0d %0d %0d %0d",
             region_hits[0], region_hits[1], region_hits[2], region_hits[3],
             region_hits[4], region_hits[5], region_hits[6]);
    if (errors == 0 && pending == 0 && results_seen == queries_sent)
      $display("tb_closest_point_on_triangle_top: done, clean");
    else
      $display("tb_closest_point_on_triangle_top: done, errors");
    $finish;
  end

endmodule
